FILE: sv/u8sv_pkg.sv
// u8sv_pkg: shared types, constants and helper functions for the utf-8 stream validator
// no dependencies; used by all modules of the block
package u8sv_pkg;

    // longest sequence allowed by the old utf-8 form
    localparam logic [2:0] MAX_SEQ_BYTES = 3'd6;

    // byte classes
    localparam logic [7:0] CLASS_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE   = 8'h80;
    localparam logic [7:0] LEAD_MIN    = 8'hC0;
    localparam logic [7:0] PAYLOAD_MSK = 8'h3F;
    localparam logic [7:0] TERM_BYTE   = 8'h00;

    // code point limits
    localparam logic [30:0] ACC_MASK   = 31'h7FFFFFFF;
    localparam logic [30:0] LIM_LEN1   = 31'h0000007F;
    localparam logic [30:0] LIM_LEN2   = 31'h000007FF;
    localparam logic [30:0] LIM_LEN3   = 31'h0000FFFF;
    localparam logic [30:0] LIM_LEN4   = 31'h001FFFFF;
    localparam logic [30:0] LIM_LEN5   = 31'h03FFFFFF;
    localparam logic [30:0] SURR_LO    = 31'h0000D800;
    localparam logic [30:0] SURR_HI    = 31'h0000DFFF;
    localparam logic [30:0] NONCHAR_LO = 31'h0000FFFE;
    localparam logic [30:0] NONCHAR_HI = 31'h0000FFFF;

    typedef logic [30:0] t_code;
    typedef logic [2:0]  t_count;
    typedef logic [3:0]  t_ones;

    // open sequence as seen by the closing check
    typedef struct packed {
        t_code  code_accum;
        t_count seq_count;
        t_ones  lead_ones;
    } t_seq_state;

    // leading one bits of a byte, 0..8
    function automatic t_ones count_lead_ones(input logic [7:0] b);
        t_ones n;
        logic  run;
        n   = '0;
        run = 1'b1;
        for (int i = 7; i >= 0; i--) begin
            run = run & b[i];
            if (run) begin
                n = n + 4'd1;
            end
        end
        return n;
    endfunction

    // shortest encoding length of a code point
    function automatic t_count shortest_length(input t_code u);
        t_count len;
        if (u <= LIM_LEN1) begin
            len = 3'd1;
        end else if (u <= LIM_LEN2) begin
            len = 3'd2;
        end else if (u <= LIM_LEN3) begin
            len = 3'd3;
        end else if (u <= LIM_LEN4) begin
            len = 3'd4;
        end else if (u <= LIM_LEN5) begin
            len = 3'd5;
        end else begin
            len = 3'd6;
        end
        return len;
    endfunction

endpackage

FILE: sv/u8sv_if.sv
// u8sv_byte_if, u8sv_result_if: valid/ready channels of the utf-8 stream validator
// no dependencies beyond plain logic types
interface u8sv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface u8sv_result_if;
    logic valid;
    logic ready;
    logic is_valid;

    modport source (output valid, output is_valid, input ready);
    modport sink   (input valid, input is_valid, output ready);
endinterface

FILE: sv/u8sv_check.sv
// u8sv_check: decides whether the open sequence is malformed when it closes
// depends on u8sv_pkg
module u8sv_check (
    input  u8sv_pkg::t_seq_state i_seq,
    output logic                 o_seq_bad
);

    logic w_len_bad;
    logic w_surrogate;
    logic w_nonchar;
    logic w_overlong;

    // individual rules on the decoded value
    assign w_len_bad   = (i_seq.seq_count == 3'd1)
                         || (i_seq.lead_ones != {1'b0, i_seq.seq_count});
    assign w_surrogate = (i_seq.code_accum >= u8sv_pkg::SURR_LO)
                         && (i_seq.code_accum <= u8sv_pkg::SURR_HI);
    assign w_nonchar   = (i_seq.code_accum == u8sv_pkg::NONCHAR_LO)
                         || (i_seq.code_accum == u8sv_pkg::NONCHAR_HI);
    assign w_overlong  = u8sv_pkg::shortest_length(i_seq.code_accum) != i_seq.seq_count;

    // only an open sequence can be bad
    assign o_seq_bad = (i_seq.seq_count != '0)
                       && (w_len_bad || w_surrogate || w_nonchar || w_overlong);

endmodule

FILE: sv/u8sv_core.sv
// u8sv_core: sequence state and per-byte update of the utf-8 stream validator
// depends on u8sv_pkg and u8sv_check
module u8sv_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_is_valid
);

    u8sv_pkg::t_code  r_code_accum, n_code_accum;
    u8sv_pkg::t_count r_seq_count,  n_seq_count;
    u8sv_pkg::t_ones  r_lead_ones,  n_lead_ones;
    logic             r_error_seen, n_error_seen;

    u8sv_pkg::t_seq_state w_seq;
    u8sv_pkg::t_ones      w_ones;
    logic                 w_seq_bad;
    logic                 w_is_cont;
    logic                 w_err_closed;

    assign w_seq.code_accum = r_code_accum;
    assign w_seq.seq_count  = r_seq_count;
    assign w_seq.lead_ones  = r_lead_ones;

    // closing check on the open sequence
    u8sv_check u_check (
        .i_seq     (w_seq),
        .o_seq_bad (w_seq_bad)
    );

    assign w_is_cont    = (i_byte & u8sv_pkg::CLASS_MASK) == u8sv_pkg::CONT_CODE;
    assign w_ones       = u8sv_pkg::count_lead_ones(i_byte);
    assign w_err_closed = r_error_seen | w_seq_bad;
    assign o_is_valid   = ~w_err_closed;

    // next state for one byte
    always_comb begin
        n_code_accum = r_code_accum;
        n_seq_count  = r_seq_count;
        n_lead_ones  = r_lead_ones;
        n_error_seen = r_error_seen;
        if (i_step) begin
            if (w_is_cont) begin
                if ((r_seq_count == '0) || (r_seq_count >= u8sv_pkg::MAX_SEQ_BYTES)) begin
                    n_error_seen = 1'b1;
                end else begin
                    n_code_accum = {r_code_accum[24:0], i_byte[5:0]}
                                   & u8sv_pkg::ACC_MASK;
                    n_seq_count  = r_seq_count + 3'd1;
                end
            end else begin
                n_code_accum = '0;
                n_seq_count  = '0;
                n_lead_ones  = '0;
                if (i_byte == u8sv_pkg::TERM_BYTE) begin
                    n_error_seen = 1'b0;
                end else begin
                    n_error_seen = w_err_closed;
                    if (i_byte >= u8sv_pkg::LEAD_MIN) begin
                        n_lead_ones  = w_ones;
                        n_seq_count  = 3'd1;
                        n_code_accum = (w_ones >= 4'd8) ? '0
                                       : {23'd0, i_byte & (8'hFF >> w_ones)};
                    end
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_accum <= '0;
            r_seq_count  <= '0;
            r_lead_ones  <= '0;
            r_error_seen <= 1'b0;
        end else begin
            r_code_accum <= n_code_accum;
            r_seq_count  <= n_seq_count;
            r_lead_ones  <= n_lead_ones;
            r_error_seen <= n_error_seen;
        end
    end

    // sequence length never passes the limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq_count <= u8sv_pkg::MAX_SEQ_BYTES)
        else $error("sequence count beyond limit");

    // lead ones and count are zero together
    a_open_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq_count == '0) == (r_lead_ones == '0))
        else $error("lead ones and sequence count disagree");

    // no open sequence means an empty accumulator
    a_accum_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq_count == '0) |-> (r_code_accum == '0))
        else $error("accumulator not empty with no open sequence");

    // terminator returns everything to reset state
    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_byte == u8sv_pkg::TERM_BYTE)) |=>
        ((r_seq_count == '0) && !r_error_seen && (r_code_accum == '0)))
        else $error("state not cleared after terminator");

endmodule

FILE: sv/utf8_stream_validator.sv
// utf8_stream_validator: top level with input register, sequence core and result register
// depends on u8sv_pkg, u8sv_if and u8sv_core
// the result for a terminator byte goes from the input register through the core into the result register
// throughput: one byte per cycle; a terminator waits only while an earlier result is untaken
// reset (i_rst_n low, synchronous): pipeline empty, no open sequence, error flag clear
module utf8_stream_validator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    u8sv_byte_if.sink            i_in,
    u8sv_result_if.source        o_out
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_out_vld;
    logic       r_out_is_valid;

    logic w_term;
    logic w_adv;
    logic w_is_valid;

    // a byte moves on unless it is a terminator facing a full result register
    assign w_term    = r_in_byte == u8sv_pkg::TERM_BYTE;
    assign w_adv     = r_in_vld && (!w_term || !r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
        end
    end

    u8sv_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_adv),
        .i_byte     (r_in_byte),
        .o_is_valid (w_is_valid)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && w_term) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_term) begin
            r_out_is_valid <= w_is_valid;
        end
    end

    assign o_out.valid    = r_out_vld;
    assign o_out.is_valid = r_out_is_valid;

endmodule

FILE: dv/utf8_stream_validator_test.sv
// utf8_stream_validator_test: self-checking testbench for the utf-8 stream validator
// depends on u8sv_pkg, u8sv_if and utf8_stream_validator; drives bytes in, checks verdicts out
// a local decoder predicts each string verdict, random idling and one long output hold
module utf8_stream_validator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 480;
    localparam int MIN_STRINGS  = 40;
    localparam int MAX_REPORTS  = 40;

    logic i_clk;
    logic i_rst_n;

    u8sv_byte_if   byte_ch();
    u8sv_result_if verdict_ch();

    utf8_stream_validator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (verdict_ch)
    );

    // decoder state mirrored from the block
    u8sv_pkg::t_code  code_acc   = '0;
    u8sv_pkg::t_count open_len   = '0;
    u8sv_pkg::t_ones  lead_run   = '0;
    logic             string_bad = 1'b0;

    // verdicts predicted for terminated strings, oldest first
    logic expected_verdicts[$];

    // bytes of the string being built
    logic [7:0] str_buf[$];

    int   mismatch_count = 0;
    int   verdicts_seen  = 0;
    int   bytes_sent     = 0;
    int   cycle_count    = 0;
    int   hold_req_cnt   = 0;
    int   hold_served    = 0;
    logic steady_mode;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (steady_mode) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // ---------------------------------------------------------------
    // verdict predictor

    function automatic u8sv_pkg::t_ones leading_ones(input logic [7:0] b);
        u8sv_pkg::t_ones n;
        n = '0;
        for (int i = 7; i >= 0 && b[i]; i--) begin
            n = n + 4'd1;
        end
        return n;
    endfunction

    function automatic u8sv_pkg::t_count min_encoding_len(input u8sv_pkg::t_code u);
        if (u <= u8sv_pkg::LIM_LEN1) begin
            return 3'd1;
        end
        if (u <= u8sv_pkg::LIM_LEN2) begin
            return 3'd2;
        end
        if (u <= u8sv_pkg::LIM_LEN3) begin
            return 3'd3;
        end
        if (u <= u8sv_pkg::LIM_LEN4) begin
            return 3'd4;
        end
        if (u <= u8sv_pkg::LIM_LEN5) begin
            return 3'd5;
        end
        return 3'd6;
    endfunction

    // judge the open sequence, then empty it
    function automatic void close_open_sequence();
        if (open_len != 0) begin
            if (open_len == 3'd1 || u8sv_pkg::t_ones'(open_len) != lead_run) begin
                string_bad = 1'b1;
            end else if (code_acc >= u8sv_pkg::SURR_LO && code_acc <= u8sv_pkg::SURR_HI) begin
                string_bad = 1'b1;
            end else if (code_acc == u8sv_pkg::NONCHAR_LO
                         || code_acc == u8sv_pkg::NONCHAR_HI) begin
                string_bad = 1'b1;
            end else if (min_encoding_len(code_acc) != open_len) begin
                string_bad = 1'b1;
            end
        end
        open_len = '0;
        lead_run = '0;
        code_acc = '0;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        if ((b & u8sv_pkg::CLASS_MASK) == u8sv_pkg::CONT_CODE) begin
            // continuation: stray or past the longest sequence is an error
            if (open_len == 0 || open_len >= u8sv_pkg::MAX_SEQ_BYTES) begin
                string_bad = 1'b1;
            end else begin
                code_acc = {code_acc[24:0], b[5:0]};
                open_len = open_len + 3'd1;
            end
        end else begin
            close_open_sequence();
            if (b == u8sv_pkg::TERM_BYTE) begin
                expected_verdicts.push_back(!string_bad);
                string_bad = 1'b0;
            end else if (b >= u8sv_pkg::LEAD_MIN) begin
                lead_run = leading_ones(b);
                open_len = 3'd1;
                code_acc = (lead_run >= 4'd8) ? '0
                           : u8sv_pkg::t_code'(b & (8'hFF >> lead_run));
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // byte sender

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        @(posedge i_clk);
        while (!byte_ch.ready) begin
            @(posedge i_clk);
        end
        absorb_byte(b);
        bytes_sent++;
    endtask

    // send the buffered bytes and the terminator
    task automatic send_string();
        foreach (str_buf[i]) begin
            send_byte(str_buf[i]);
        end
        send_byte(u8sv_pkg::TERM_BYTE);
        str_buf.delete();
    endtask

    // ---------------------------------------------------------------
    // verdict receiver: random stalls, long holds on request

    initial begin : verdict_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        verdict_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                verdict_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_req_cnt != hold_served) begin
                verdict_ch.ready <= 1'b0;
                hold_served++;
                hold_left = HOLD_CYCLES - 1;
            end else if (stall_left > 0) begin
                verdict_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                verdict_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // compare each taken verdict with the oldest prediction
    always @(posedge i_clk) begin : verdict_check
        logic want;
        if (i_rst_n && verdict_ch.valid && verdict_ch.ready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch($sformatf("verdict %0d arrived with none pending",
                                          verdicts_seen));
            end else begin
                want = expected_verdicts.pop_front();
                if (verdict_ch.is_valid !== want) begin
                    report_mismatch($sformatf("verdict %0d: is_valid %b, expected %b",
                                              verdicts_seen, verdict_ch.is_valid, want));
                end
            end
            verdicts_seen++;
        end
    end

    // ---------------------------------------------------------------
    // string builders

    function automatic u8sv_pkg::t_code band_top(input int len);
        case (len)
            1:       return u8sv_pkg::LIM_LEN1;
            2:       return u8sv_pkg::LIM_LEN2;
            3:       return u8sv_pkg::LIM_LEN3;
            4:       return u8sv_pkg::LIM_LEN4;
            5:       return u8sv_pkg::LIM_LEN5;
            default: return u8sv_pkg::ACC_MASK;
        endcase
    endfunction

    function automatic u8sv_pkg::t_code band_floor(input int len);
        return band_top(len - 1) + 31'd1;
    endfunction

    // code point for a sequence of len bytes, edges and surrogates favored
    function automatic u8sv_pkg::t_code pick_code_value(input int len);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return band_floor(len);
        end
        if (r == 1) begin
            return band_top(len);
        end
        if (r == 2 && len == 3) begin
            case ($urandom_range(0, 5))
                0:       return u8sv_pkg::SURR_LO - 31'd1;
                1:       return u8sv_pkg::SURR_LO;
                2:       return u8sv_pkg::SURR_HI;
                3:       return u8sv_pkg::SURR_HI + 31'd1;
                4:       return u8sv_pkg::NONCHAR_LO;
                default: return u8sv_pkg::NONCHAR_HI;
            endcase
        end
        return u8sv_pkg::t_code'($urandom_range(32'(band_top(len)), 32'(band_floor(len))));
    endfunction

    // first keep bytes of the len-byte encoding of v
    task automatic append_encoded(input u8sv_pkg::t_code v, input int len, input int keep);
        logic [7:0] b;
        for (int k = 0; k < keep; k++) begin
            if (k == 0) begin
                b = ~(8'hFF >> len) | 8'(v >> (6 * (len - 1)));
            end else begin
                b = u8sv_pkg::CONT_CODE
                    | (8'(v >> (6 * (len - 1 - k))) & u8sv_pkg::PAYLOAD_MSK);
            end
            str_buf.push_back(b);
        end
    endtask

    // one character, mostly well formed, sometimes broken
    task automatic add_random_unit();
        int              r;
        int              len;
        u8sv_pkg::t_code v;
        r   = $urandom_range(0, 99);
        len = $urandom_range(2, 6);
        if (r < 30) begin
            str_buf.push_back(8'($urandom_range(1, 8'h7F)));
        end else if (r < 80) begin
            append_encoded(pick_code_value(len), len, len);
        end else if (r < 84) begin
            // overlong
            v = u8sv_pkg::t_code'($urandom_range(0, 32'(band_top(len - 1))));
            append_encoded(v, len, len);
        end else if (r < 88) begin
            // truncated
            append_encoded(pick_code_value(len), len, $urandom_range(1, len - 1));
        end else if (r < 91) begin
            // stray continuation
            str_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else if (r < 94) begin
            // one continuation too many
            append_encoded(pick_code_value(len), len, len);
            str_buf.push_back(u8sv_pkg::CONT_CODE | 8'($urandom_range(0, 8'h3F)));
        end else if (r < 97) begin
            // lead with seven or eight ones
            str_buf.push_back(8'($urandom_range(8'hFE, 8'hFF)));
            repeat ($urandom_range(0, 6)) begin
                str_buf.push_back(u8sv_pkg::CONT_CODE | 8'($urandom_range(0, 8'h3F)));
            end
        end else begin
            str_buf.push_back(8'($urandom_range(1, 8'hFF)));
        end
    endtask

    // ---------------------------------------------------------------
    // tests

    task automatic test_edge_strings();
        // empty string
        str_buf.delete();
        send_string();
        // ascii and two-byte extremes
        str_buf = '{8'h01, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF};
        send_string();
        // largest six-byte value
        str_buf = '{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
        send_string();
        // seven bytes in one sequence
        str_buf = '{8'hFC, 8'h84, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
        send_string();
        // stray continuation
        str_buf = '{8'h80};
        send_string();
        // lone lead closed by ascii
        str_buf = '{8'hC3, 8'h41};
        send_string();
        // overlong
        str_buf = '{8'hC0, 8'h80};
        send_string();
        // surrogate
        str_buf = '{8'hED, 8'hA0, 8'h80};
        send_string();
        // noncharacter
        str_buf = '{8'hEF, 8'hBF, 8'hBE};
        send_string();
        // seven and eight leading ones
        str_buf = '{8'hFE};
        send_string();
        str_buf = '{8'hFF, 8'h80};
        send_string();
    endtask

    // receiver holds off while short strings keep coming, so the input stalls
    task automatic test_output_hold();
        steady_mode  <= 1'b1;
        hold_req_cnt <= hold_req_cnt + 1;
        repeat (16) begin
            str_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
            send_string();
        end
        steady_mode <= 1'b0;
    endtask

    task automatic test_random_strings();
        int strings;
        int start_bytes;
        int units;
        strings     = 0;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES || strings < MIN_STRINGS) begin
            if ($urandom_range(0, 9) == 0) begin
                steady_mode <= ~steady_mode;
            end
            units = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 5);
            repeat (units) begin
                add_random_unit();
            end
            send_string();
            strings++;
        end
        steady_mode <= 1'b0;
    endtask

    task automatic finish_run();
        byte_ch.valid <= 1'b0;
        while (expected_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    endtask

    // reset, then the tests in turn
    initial begin
        i_rst_n           <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= 8'h00;
        steady_mode       <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_edge_strings();
        test_output_hold();
        test_random_strings();
        finish_run();
    end

endmodule
